// ===== rtl/core/slc_pkg.sv =====
// Shared types, constants and translation tables for the scancode line editor.
`timescale 1ns / 1ps
package slc_pkg;

  localparam int unsigned LINE_DEPTH  = 256;
  localparam int unsigned LINE_ADDR_W = $clog2(LINE_DEPTH);
  localparam int unsigned STORE_W     = 8;

  localparam logic [7:0] LINE_LIMIT = 8'd254;
  localparam logic [7:0] LAST_MAKE  = 8'h3A;
  localparam logic [7:0] LSHIFT     = 8'h2A;
  localparam logic [7:0] RSHIFT     = 8'h36;
  localparam logic [7:0] BACKSPACE  = 8'h0E;
  localparam logic [7:0] F1_CODE    = 8'h3B;
  localparam logic [7:0] F5_CODE    = 8'h3F;
  localparam logic [7:0] RELEASE    = 8'h80;
  localparam logic [6:0] NEWLINE    = 7'h0A;

  localparam logic OP_SCAN  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef struct packed {
    logic       operation;
    logic [7:0] scan_byte;
  } in_req_t;

  typedef struct packed {
    logic       echo_valid;
    logic [6:0] echo_char;
    logic       erase_valid;
    logic       screen_valid;
    logic [2:0] screen_index;
    logic       store_valid;
    logic [7:0] store_pos;
    logic [6:0] store_char;
    logic       line_complete;
    logic [7:0] line_length;
  } out_rsp_t;

  function automatic logic [6:0] plain_char(input logic [5:0] idx);
    logic [6:0] c;
    case (idx)
      6'd1:    c = 7'h1B;
      6'd2:    c = 7'h31;
      6'd3:    c = 7'h32;
      6'd4:    c = 7'h33;
      6'd5:    c = 7'h34;
      6'd6:    c = 7'h35;
      6'd7:    c = 7'h36;
      6'd8:    c = 7'h37;
      6'd9:    c = 7'h38;
      6'd10:   c = 7'h39;
      6'd11:   c = 7'h30;
      6'd12:   c = 7'h2D;
      6'd13:   c = 7'h3D;
      6'd14:   c = 7'h08;
      6'd15:   c = 7'h09;
      6'd16:   c = 7'h71;
      6'd17:   c = 7'h77;
      6'd18:   c = 7'h65;
      6'd19:   c = 7'h72;
      6'd20:   c = 7'h74;
      6'd21:   c = 7'h79;
      6'd22:   c = 7'h75;
      6'd23:   c = 7'h69;
      6'd24:   c = 7'h6F;
      6'd25:   c = 7'h70;
      6'd26:   c = 7'h5B;
      6'd27:   c = 7'h5D;
      6'd28:   c = 7'h0A;
      6'd30:   c = 7'h61;
      6'd31:   c = 7'h73;
      6'd32:   c = 7'h64;
      6'd33:   c = 7'h66;
      6'd34:   c = 7'h67;
      6'd35:   c = 7'h68;
      6'd36:   c = 7'h6A;
      6'd37:   c = 7'h6B;
      6'd38:   c = 7'h6C;
      6'd39:   c = 7'h3B;
      6'd40:   c = 7'h27;
      6'd41:   c = 7'h60;
      6'd43:   c = 7'h5C;
      6'd44:   c = 7'h7A;
      6'd45:   c = 7'h78;
      6'd46:   c = 7'h63;
      6'd47:   c = 7'h76;
      6'd48:   c = 7'h62;
      6'd49:   c = 7'h6E;
      6'd50:   c = 7'h6D;
      6'd51:   c = 7'h2C;
      6'd52:   c = 7'h2E;
      6'd53:   c = 7'h2F;
      6'd55:   c = 7'h2A;
      6'd57:   c = 7'h20;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

  function automatic logic [6:0] shift_char(input logic [5:0] idx);
    logic [6:0] c;
    case (idx)
      6'd2:    c = 7'h21;
      6'd3:    c = 7'h40;
      6'd4:    c = 7'h23;
      6'd5:    c = 7'h24;
      6'd6:    c = 7'h25;
      6'd7:    c = 7'h5E;
      6'd8:    c = 7'h26;
      6'd9:    c = 7'h2A;
      6'd10:   c = 7'h28;
      6'd11:   c = 7'h29;
      6'd12:   c = 7'h5F;
      6'd13:   c = 7'h2B;
      6'd16:   c = 7'h51;
      6'd17:   c = 7'h57;
      6'd18:   c = 7'h45;
      6'd19:   c = 7'h52;
      6'd20:   c = 7'h54;
      6'd21:   c = 7'h59;
      6'd22:   c = 7'h55;
      6'd23:   c = 7'h49;
      6'd24:   c = 7'h4F;
      6'd25:   c = 7'h50;
      6'd26:   c = 7'h7B;
      6'd27:   c = 7'h7D;
      6'd28:   c = 7'h0A;
      6'd30:   c = 7'h41;
      6'd31:   c = 7'h53;
      6'd32:   c = 7'h44;
      6'd33:   c = 7'h46;
      6'd34:   c = 7'h47;
      6'd35:   c = 7'h48;
      6'd36:   c = 7'h4A;
      6'd37:   c = 7'h4B;
      6'd38:   c = 7'h4C;
      6'd39:   c = 7'h3A;
      6'd40:   c = 7'h22;
      6'd41:   c = 7'h7E;
      6'd43:   c = 7'h7C;
      6'd44:   c = 7'h5A;
      6'd45:   c = 7'h58;
      6'd46:   c = 7'h43;
      6'd47:   c = 7'h56;
      6'd48:   c = 7'h42;
      6'd49:   c = 7'h4E;
      6'd50:   c = 7'h4D;
      6'd51:   c = 7'h3C;
      6'd52:   c = 7'h3E;
      6'd53:   c = 7'h3F;
      6'd55:   c = 7'h2A;
      6'd57:   c = 7'h20;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/core/slc_ram.sv =====
// Generic single-clock RAM, one write port and one registered write-first read port.
`timescale 1ns / 1ps
module slc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data <= wr_data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

endmodule

// ===== rtl/core/scancode_line_editor_core.sv =====
// Top level of the set-1 scancode line editor with its line store.
//
//   channel | ports                          | payload
//   input   | in_valid, in_ready, in_data    | slc_pkg::in_req_t
//   result  | out_valid, out_ready, out_data | slc_pkg::out_rsp_t
//
// One request per cycle unless output stalls; results register in p_r, then o_r.
// Shift, length and complete state update at acceptance; the line store RAM is
// written in the same cycle and its registered read returns the stored byte.
// A stalled result holds the output and the stage behind it; input is taken
// while either stage has room. Reset leaves the store unread, so no clear pass.
`timescale 1ns / 1ps
module scancode_line_editor_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  slc_pkg::in_req_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output slc_pkg::out_rsp_t out_data
);

  logic              shift_r, shift_nxt;
  logic [7:0]        len_r, len_nxt;
  logic              cmpl_r, cmpl_nxt;
  logic              pv_r;
  slc_pkg::out_rsp_t p_r, p_nxt;
  logic              ov_r;
  slc_pkg::out_rsp_t o_r, o_nxt;
  logic              o_free;
  logic              accept;
  logic [6:0]        wr_char;
  logic [slc_pkg::STORE_W-1:0] rd_data;

  assign o_free   = !ov_r || out_ready;
  assign in_ready = !pv_r || o_free;
  assign accept   = in_valid && in_ready;

  always_comb begin
    logic [7:0] sc;
    logic [6:0] ch;
    sc        = in_data.scan_byte;
    shift_nxt = shift_r;
    len_nxt   = len_r;
    cmpl_nxt  = cmpl_r;
    p_nxt     = '0;
    wr_char   = 7'd0;
    ch        = shift_r ? slc_pkg::shift_char(sc[5:0]) : slc_pkg::plain_char(sc[5:0]);
    if (in_data.operation == slc_pkg::OP_CLEAR) begin
      len_nxt  = 8'd0;
      cmpl_nxt = 1'b0;
    end else if ((len_r < slc_pkg::LINE_LIMIT) && (sc <= slc_pkg::LAST_MAKE)) begin
      if ((sc == slc_pkg::LSHIFT) || (sc == slc_pkg::RSHIFT)) begin
        shift_nxt = 1'b1;
      end else if (sc == slc_pkg::BACKSPACE) begin
        if (len_r != 8'd0) begin
          len_nxt           = len_r - 8'd1;
          p_nxt.erase_valid = 1'b1;
          p_nxt.store_valid = 1'b1;
          p_nxt.store_pos   = len_r - 8'd1;
        end
      end else begin
        p_nxt.echo_valid  = 1'b1;
        p_nxt.echo_char   = ch;
        p_nxt.store_valid = 1'b1;
        p_nxt.store_pos   = len_r;
        if (!shift_r && (ch == slc_pkg::NEWLINE)) begin
          cmpl_nxt = 1'b1;
        end else begin
          wr_char = ch;
          len_nxt = len_r + 8'd1;
        end
      end
    end else if ((sc >= slc_pkg::F1_CODE) && (sc <= slc_pkg::F5_CODE)) begin
      p_nxt.screen_valid = 1'b1;
      p_nxt.screen_index = 3'(sc - slc_pkg::F1_CODE);
    end else if ((sc == (slc_pkg::LSHIFT | slc_pkg::RELEASE)) ||
                 (sc == (slc_pkg::RSHIFT | slc_pkg::RELEASE))) begin
      shift_nxt = 1'b0;
    end
    p_nxt.line_complete = cmpl_nxt;
    p_nxt.line_length   = len_nxt;
  end

  slc_ram #(
    .WIDTH(slc_pkg::STORE_W),
    .DEPTH(slc_pkg::LINE_DEPTH)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (accept && p_nxt.store_valid),
    .wr_addr (slc_pkg::LINE_ADDR_W'(p_nxt.store_pos)),
    .wr_data ({1'b0, wr_char}),
    .rd_en   (accept),
    .rd_addr (slc_pkg::LINE_ADDR_W'(p_nxt.store_pos)),
    .rd_data (rd_data)
  );

  always_comb begin
    o_nxt            = p_r;
    o_nxt.store_char = p_r.store_valid ? rd_data[6:0] : 7'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r <= 1'b0;
      len_r   <= 8'd0;
      cmpl_r  <= 1'b0;
      pv_r    <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      if (accept) begin
        shift_r <= shift_nxt;
        len_r   <= len_nxt;
        cmpl_r  <= cmpl_nxt;
      end
      if (in_ready) begin
        pv_r <= in_valid;
      end
      if (o_free) begin
        ov_r <= pv_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_r <= p_nxt;
    end
    if (o_free && pv_r) begin
      o_r <= o_nxt;
    end
  end

  assign out_valid = ov_r;
  assign out_data  = o_r;

endmodule

// ===== tb/slc_line_checker.sv =====
// Checker that predicts line editor results from accepted requests and compares them.
`timescale 1ns / 1ps
module slc_line_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  slc_pkg::in_req_t  in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  slc_pkg::out_rsp_t out_data,
  output int                fail_count,
  output int                pending
);

  logic [6:0] plain_keymap [0:58] = '{
    7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
    7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
    7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
    7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
    7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20, 7'h00
  };

  logic [6:0] shift_keymap [0:58] = '{
    7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
    7'h28, 7'h29, 7'h5F, 7'h2B, 7'h00, 7'h00, 7'h51, 7'h57, 7'h45, 7'h52,
    7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
    7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
    7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
    7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20, 7'h00
  };

  logic              shift_down;
  logic [7:0]        cur_len;
  logic              done_flag;
  logic [7:0]        line_mem [0:slc_pkg::LINE_DEPTH-1];
  slc_pkg::out_rsp_t expected_rsp [$];

  initial fail_count = 0;

  function automatic slc_pkg::out_rsp_t edit_line(input slc_pkg::in_req_t req);
    slc_pkg::out_rsp_t r;
    logic [7:0]        sc;
    logic [6:0]        ch;
    r  = '0;
    sc = req.scan_byte;
    if (req.operation == slc_pkg::OP_CLEAR) begin
      cur_len   = '0;
      done_flag = 1'b0;
    end else if (cur_len < slc_pkg::LINE_LIMIT && sc <= slc_pkg::LAST_MAKE) begin
      if (sc == slc_pkg::LSHIFT || sc == slc_pkg::RSHIFT) begin
        shift_down = 1'b1;
      end else if (sc == slc_pkg::BACKSPACE) begin
        if (cur_len != 0) begin
          cur_len           = cur_len - 8'd1;
          r.erase_valid     = 1'b1;
          r.store_valid     = 1'b1;
          r.store_pos       = cur_len;
          r.store_char      = '0;
          line_mem[cur_len] = '0;
        end
      end else begin
        ch            = shift_down ? shift_keymap[sc] : plain_keymap[sc];
        r.echo_valid  = 1'b1;
        r.echo_char   = ch;
        r.store_valid = 1'b1;
        r.store_pos   = cur_len;
        if (!shift_down && ch == slc_pkg::NEWLINE) begin
          r.store_char = '0;
          done_flag    = 1'b1;
        end else begin
          r.store_char = ch;
          cur_len      = cur_len + 8'd1;
        end
        line_mem[r.store_pos] = {1'b0, r.store_char};
      end
    end else if (sc >= slc_pkg::F1_CODE && sc <= slc_pkg::F5_CODE) begin
      r.screen_valid = 1'b1;
      r.screen_index = 3'(sc - slc_pkg::F1_CODE);
    end else if (sc == (slc_pkg::LSHIFT | slc_pkg::RELEASE) ||
                 sc == (slc_pkg::RSHIFT | slc_pkg::RELEASE)) begin
      shift_down = 1'b0;
    end
    r.line_complete = done_flag;
    r.line_length   = cur_len;
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      fail_count++;
      $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    slc_pkg::out_rsp_t want;
    if (!rst_n) begin
      shift_down = 1'b0;
      cur_len    = '0;
      done_flag  = 1'b0;
      foreach (line_mem[i]) line_mem[i] = '0;
      expected_rsp.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_rsp.size() == 0) begin
          fail_count++;
          $display("%0t: result expected none, actual %h", $time, out_data);
        end else begin
          want = expected_rsp.pop_front();
          check_field("echo_valid", want.echo_valid, out_data.echo_valid);
          check_field("echo_char", want.echo_char, out_data.echo_char);
          check_field("erase_valid", want.erase_valid, out_data.erase_valid);
          check_field("screen_valid", want.screen_valid, out_data.screen_valid);
          check_field("screen_index", want.screen_index, out_data.screen_index);
          check_field("store_valid", want.store_valid, out_data.store_valid);
          check_field("store_pos", want.store_pos, out_data.store_pos);
          check_field("store_char", want.store_char, out_data.store_char);
          check_field("line_complete", want.line_complete, out_data.line_complete);
          check_field("line_length", want.line_length, out_data.line_length);
        end
      end
      if (in_valid && in_ready) expected_rsp.push_back(edit_line(in_data));
    end
    pending <= expected_rsp.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// Top of the line editor testbench: clock, reset, request stimulus, result stalls and verdict.
`timescale 1ns / 1ps
module tb_top;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 80;
  localparam int PHASE_ITEMS = 385;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  slc_pkg::in_req_t  in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  slc_pkg::out_rsp_t out_data;

  int fail_count;
  int pending;
  int cycle_count = 0;
  int sent_count = 0;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int hold_seq = 0;

  always #5 clk = ~clk;

  scancode_line_editor_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  slc_line_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin : receiver
    int hold_seen;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  task automatic send_req(input logic op, input logic [7:0] code);
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= '{operation: op, scan_byte: code};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_count++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_key();
    logic [7:0] c;
    do c = 8'($urandom_range(slc_pkg::LAST_MAKE));
    while (c == slc_pkg::LSHIFT || c == slc_pkg::RSHIFT || c == slc_pkg::BACKSPACE);
    return c;
  endfunction

  task automatic type_word(input int n, input bit shifted);
    logic [7:0] sk;
    logic [7:0] rk;
    sk = $urandom_range(1) ? slc_pkg::LSHIFT : slc_pkg::RSHIFT;
    rk = ($urandom_range(1) ? slc_pkg::LSHIFT : slc_pkg::RSHIFT) | slc_pkg::RELEASE;
    if (shifted) send_req(slc_pkg::OP_SCAN, sk);
    repeat (n) send_req(slc_pkg::OP_SCAN, pick_key());
    if (shifted) send_req(slc_pkg::OP_SCAN, rk);
  endtask

  task automatic fill_line();
    send_req(slc_pkg::OP_CLEAR, 8'($urandom));
    send_req(slc_pkg::OP_SCAN, slc_pkg::LSHIFT | slc_pkg::RELEASE);
    repeat (275) send_req(slc_pkg::OP_SCAN, pick_key());
    send_req(slc_pkg::OP_SCAN, slc_pkg::BACKSPACE);
    send_req(slc_pkg::OP_SCAN, slc_pkg::LSHIFT);
    send_req(slc_pkg::OP_SCAN, pick_key());
    send_req(slc_pkg::OP_SCAN, slc_pkg::LAST_MAKE);
    send_req(slc_pkg::OP_SCAN, 8'h00);
    send_req(slc_pkg::OP_SCAN, 8'($urandom_range(slc_pkg::F1_CODE, slc_pkg::F5_CODE)));
    send_req(slc_pkg::OP_SCAN, slc_pkg::RSHIFT | slc_pkg::RELEASE);
    send_req(slc_pkg::OP_SCAN, 8'($urandom));
    send_req(slc_pkg::OP_CLEAR, 8'($urandom));
    send_req(slc_pkg::OP_SCAN, slc_pkg::BACKSPACE);
  endtask

  initial begin : stimulus
    int ph;
    int phase_end;
    int sel;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_req(slc_pkg::OP_SCAN, slc_pkg::BACKSPACE);
    send_req(slc_pkg::OP_CLEAR, 8'hFF);
    send_req(slc_pkg::OP_SCAN, 8'h1E);
    send_req(slc_pkg::OP_SCAN, 8'h00);
    send_req(slc_pkg::OP_SCAN, slc_pkg::LAST_MAKE);
    send_req(slc_pkg::OP_SCAN, 8'h01);
    send_req(slc_pkg::OP_SCAN, slc_pkg::LSHIFT);
    send_req(slc_pkg::OP_SCAN, 8'h1E);
    send_req(slc_pkg::OP_SCAN, 8'h1C);
    send_req(slc_pkg::OP_SCAN, slc_pkg::LAST_MAKE);
    send_req(slc_pkg::OP_SCAN, slc_pkg::LSHIFT | slc_pkg::RELEASE);
    send_req(slc_pkg::OP_SCAN, slc_pkg::RSHIFT);
    send_req(slc_pkg::OP_SCAN, 8'h02);
    send_req(slc_pkg::OP_SCAN, slc_pkg::RSHIFT | slc_pkg::RELEASE);
    send_req(slc_pkg::OP_SCAN, 8'h1C);
    send_req(slc_pkg::OP_SCAN, slc_pkg::BACKSPACE);
    send_req(slc_pkg::OP_SCAN, slc_pkg::F1_CODE);
    send_req(slc_pkg::OP_SCAN, slc_pkg::F5_CODE);
    send_req(slc_pkg::OP_SCAN, slc_pkg::F5_CODE + 8'd1);
    send_req(slc_pkg::OP_SCAN, 8'hFF);
    send_req(slc_pkg::OP_SCAN, slc_pkg::RELEASE);
    send_req(slc_pkg::OP_SCAN, 8'h7F);
    send_req(slc_pkg::OP_SCAN, 8'h9C);
    send_req(slc_pkg::OP_CLEAR, 8'h00);
    send_req(slc_pkg::OP_SCAN, slc_pkg::BACKSPACE);
    drain();

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 61; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 61; end
        default: begin tx_idle_pct = 35; rx_stall_pct = 35; end
      endcase
      phase_end = sent_count + PHASE_ITEMS;
      if (ph == 0 || ph == 2) hold_seq++;
      if (ph == 1 || ph == 3) fill_line();
      while (sent_count < phase_end) begin
        sel = $urandom_range(99);
        if (sel < 50) begin
          type_word($urandom_range(1, 20), $urandom_range(2) == 0);
        end else if (sel < 62) begin
          repeat ($urandom_range(1, 8)) send_req(slc_pkg::OP_SCAN, slc_pkg::BACKSPACE);
        end else if (sel < 66) begin
          send_req(slc_pkg::OP_CLEAR, 8'($urandom));
        end else if (sel < 76) begin
          if ($urandom_range(1))
            send_req(slc_pkg::OP_SCAN,
                     8'($urandom_range(slc_pkg::F1_CODE, slc_pkg::F5_CODE + 8'd5)));
          else
            send_req(slc_pkg::OP_SCAN, 8'($urandom_range(8'h80, 8'hFF)));
        end else begin
          send_req($urandom_range(9) == 0 ? slc_pkg::OP_CLEAR : slc_pkg::OP_SCAN,
                   8'($urandom));
        end
      end
      drain();
    end

    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
